[hw/rtl/cbcm_pkg.sv]
// cbcm_pkg: shared types, constants and aes helper functions for the cbc-mac block
// depends on nothing; imported by every module of the block
package cbcm_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int NUM_ROUNDS  = 10;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] data_high;
		logic [63:0] data_low;
		logic        last_block;
	} in_item_t;

	typedef struct packed {
		logic [63:0] mac_high;
		logic [63:0] mac_low;
	} out_item_t;

	typedef enum logic [0:0] {
		ENG_IDLE = 1'b0,
		ENG_RUN  = 1'b1
	} eng_state_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
		};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of the state sits at bits [127-8i -: 8]
	function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
		return s[127-8*i -: 8];
	endfunction

	// subbytes and shiftrows together
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127-8*(4*c+r) -: 8] = sbox(get_byte(s, 4*((c+r)%4)+r));
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, al;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);
			a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2);
			a3 = get_byte(s, 4*c+3);
			al = a0 ^ a1 ^ a2 ^ a3;
			t[127-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			t[127-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			t[127-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			t[127-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

	// next round key from the current one
	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic logic [7:0] rcon_next(input logic [7:0] rc);
		return xtime(rc);
	endfunction

endpackage

[hw/rtl/cbcm_queue.sv]
// cbcm_queue: small fifo of accepted blocks between the input side and the aes engine
// depends on cbcm_pkg
module cbcm_queue
	import cbcm_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	output logic     out_valid,
	input  logic     out_take,
	output in_item_t out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	in_item_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;
	logic            push, pop;

	assign in_stall  = (cnt_q == (AW+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && out_take;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

[hw/rtl/cbcm_engine.sv]
// cbcm_engine: round-iterative aes-128 with cbc chaining and a mac output register
// depends on cbcm_pkg
module cbcm_engine
	import cbcm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic [127:0] key,
	input  logic      blk_valid,
	output logic      blk_take,
	input  in_item_t  blk,
	output logic      mac_valid,
	input  logic      mac_stall,
	output out_item_t mac
);

	eng_state_t  state_q, state_d;
	logic [127:0] st_q, rk_q, chain_q;
	logic [7:0]   rc_q;
	logic [3:0]   rnd_q;
	logic         last_q, outv_q;
	out_item_t    out_q;
	logic [127:0] rk_n, st_n, ct;
	logic         done, out_free;

	assign rk_n     = next_key(rk_q, rc_q);
	assign st_n     = (rnd_q == 4'(NUM_ROUNDS)) ? sub_shift(st_q) ^ rk_n
	                                            : mix_columns(sub_shift(st_q)) ^ rk_n;
	assign ct       = st_n;
	assign done     = (state_q == ENG_RUN) && (rnd_q == 4'(NUM_ROUNDS));
	assign out_free = !outv_q || !mac_stall;

	// next state and block pickup
	always_comb begin
		state_d  = state_q;
		blk_take = 1'b0;
		unique case (state_q)
			ENG_IDLE: begin
				blk_take = blk_valid;
				if (blk_valid) state_d = ENG_RUN;
			end
			ENG_RUN: begin
				if (done && (!last_q || out_free)) begin
					blk_take = blk_valid;
					state_d  = blk_valid ? ENG_RUN : ENG_IDLE;
				end
			end
			default: state_d = ENG_IDLE;
		endcase
	end

	logic adv;
	assign adv = (state_q == ENG_RUN) && !(done && last_q && !out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENG_IDLE;
			chain_q <= '0;
			outv_q  <= 1'b0;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			if (done && adv) begin
				chain_q <= last_q ? '0 : ct;
			end
			// mac register: load a fresh mac, else drop on transfer
			if (done && adv && last_q) outv_q <= 1'b1;
			else if (!mac_stall) outv_q <= 1'b0;
			if (blk_take) rnd_q <= 4'd1;
			else if (adv && !done) rnd_q <= rnd_q + 4'd1;
		end
	end

	// round datapath; a new block starts with the initial key add
	always_ff @(posedge clk) begin
		if (blk_take) begin
			st_q   <= {blk.data_high, blk.data_low} ^ ((done) ? (last_q ? 128'd0 : ct) : chain_q)
			          ^ key;
			rk_q   <= key;
			rc_q   <= 8'h01;
			last_q <= blk.last_block;
		end else if (adv && !done) begin
			st_q <= st_n;
			rk_q <= rk_n;
			rc_q <= rcon_next(rc_q);
		end
		if (done && adv && last_q) begin
			out_q.mac_high <= ct[127:64];
			out_q.mac_low  <= ct[63:0];
		end
	end

	assign mac_valid = outv_q;
	assign mac       = out_q;

endmodule

[hw/rtl/cbc_mac_aes128.sv]
// cbc_mac_aes128: top level, key registers, input queue and aes engine
// depends on cbcm_pkg, cbcm_queue, cbcm_engine
//
// CBC-MAC over AES-128. Each accepted 128-bit block is chained and encrypted by a
// round-iterative core, one round per cycle: the initial key add happens on pickup and
// the tenth round lands on the edge that picks up the next block, so each block waits
// for the previous ciphertext. With the core idle a block is picked up from the queue
// in the cycle after its transfer, and its mac is registered as its tenth round lands. A
// two-entry queue takes blocks while the core works, and the mac sits in an output
// register while the core goes on; the core only stops when it finishes another last
// block while that register is still stalled. A mac appears only for blocks marked
// last; the chain then restarts from zero. Write the key only while idle.
module cbc_mac_aes128
	import cbcm_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [63:0] cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic [63:0] key_hi_q, key_lo_q;
	logic        q_valid, q_take;
	in_item_t    q_data;

	assign cfg_ready = 1'b1;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KEY_HIGH: key_hi_q <= cfg_data;
				REG_KEY_LOW:  key_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cbcm_queue #(.DEPTH(DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(q_valid), .out_take(q_take), .out_data(q_data)
	);

	cbcm_engine u_engine (
		.clk(clk), .arst_n(arst_n), .key({key_hi_q, key_lo_q}),
		.blk_valid(q_valid), .blk_take(q_take), .blk(q_data),
		.mac_valid(out_valid), .mac_stall(out_stall), .mac(out_data)
	);

endmodule

[hw/rtl/cbcm_checker.sv]
// cbcm_checker: port-level assertions for cbc_mac_aes128, with its bind
// depends on cbcm_pkg
module cbcm_checker
	import cbcm_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// a stalled mac holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("mac changed while stalled");

	// no mac right after reset release
	a_no_early: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("mac without input");

	// a stalled input block holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("input block changed while stalled");

	// handshake outputs of the block are always known
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_stall, out_valid}))
		else $error("unknown handshake output");

endmodule

bind cbc_mac_aes128 cbcm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
